FILE: rtl/lpd_pkg.sv
// Package: shared types and constants of the lidar packet deframer.
`timescale 1ns / 1ps

package lpd_pkg;

   localparam logic [7:0]  HDR_LO   = 8'hAA;
   localparam logic [7:0]  HDR_HI   = 8'h55;
   localparam logic [15:0] SUM_SEED = 16'h55AA;

   // byte lane of a sample triple
   localparam logic [1:0] LANE_B0 = 2'd0;
   localparam logic [1:0] LANE_B1 = 2'd1;
   localparam logic [1:0] LANE_B2 = 2'd2;

   typedef struct packed {
      logic       req_type;
      logic [7:0] rx_byte;
   } req_item_type;

   typedef struct packed {
      logic        status;
      logic [5:0]  sample_index;
      logic [7:0]  intensity;
      logic [13:0] distance;
      logic        distance_ok;
      logic [15:0] angle_start;
      logic [15:0] angle_end;
      logic [7:0]  packet_type;
      logic        end_of_cycle;
      logic        last;
      logic [31:0] error_count;
      logic [31:0] cycle_count;
   } rsp_item_type;

   typedef enum logic [3:0] {
      ST_HUNT_LO,
      ST_HUNT_HI,
      ST_TYPE,
      ST_COUNT,
      ST_FSA_LO,
      ST_FSA_HI,
      ST_LSA_LO,
      ST_LSA_HI,
      ST_CS_LO,
      ST_CS_HI,
      ST_DATA,
      ST_CHECK,
      ST_RD_ISSUE,
      ST_RD_LOAD
   } state_type;

   typedef enum logic [3:0] {
      BOP_NONE,
      BOP_TYPE,
      BOP_COUNT,
      BOP_FSA_LO,
      BOP_FSA_HI,
      BOP_LSA_LO,
      BOP_LSA_HI,
      BOP_CS_LO,
      BOP_CS_HI,
      BOP_DATA
   } byte_op_type;

   typedef struct packed {
      byte_op_type byte_op;
      logic        err_inc;
      logic        err_clr;
      logic        cyc_inc;
      logic        wr_clr;
      logic        rd_clr;
      logic        rd_issue;
      logic        load_sample;
      logic        load_error;
   } cmd_type;

   typedef struct packed {
      logic hdr_lo_ok;
      logic hdr_hi_ok;
      logic count_bad;
      logic total_zero;
      logic data_last;
      logic sum_match;
      logic eoc;
      logic read_last;
      logic slot_free;
   } status_type;

endpackage

FILE: rtl/lpd_datapath.sv
// Datapath: packet fields, checksum, sample memory, counters and result register.
`timescale 1ns / 1ps

module lpd_datapath #(
   parameter int MAX_SAMPLES = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lpd_pkg::req_item_type req_data,
   input  lpd_pkg::cmd_type     cmd,
   output lpd_pkg::status_type  sts,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output lpd_pkg::rsp_item_type rsp_data
);
   import lpd_pkg::*;

   localparam int IW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

   logic [7:0]    type_ff, type_in;
   logic [7:0]    total_ff, total_in;
   logic [15:0]   start_ff, start_in;
   logic [15:0]   end_ff, end_in;
   logic [15:0]   expect_ff, expect_in;
   logic [15:0]   sum_ff, sum_in;
   logic [1:0]    lane_ff, lane_in;
   logic [IW-1:0] wr_idx_ff, wr_idx_in;
   logic [IW-1:0] rd_idx_ff, rd_idx_in;
   logic [31:0]   errors_ff, errors_in;
   logic [31:0]   cycles_ff, cycles_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_item_type  rsp_ff, rsp_in;
   logic [7:0]    rd_b0_ff, rd_b1_ff, rd_b2_ff;
   logic [7:0]    b;
   logic [7:0]    rd_idx8;

   // one memory per byte lane, so all three bytes of a sample are read together
   logic [7:0] mem0 [MAX_SAMPLES];
   logic [7:0] mem1 [MAX_SAMPLES];
   logic [7:0] mem2 [MAX_SAMPLES];

   assign b       = req_data.rx_byte;
   assign rd_idx8 = 8'(rd_idx_ff);

   always_comb begin
      sts.hdr_lo_ok  = (b == HDR_LO);
      sts.hdr_hi_ok  = (b == HDR_HI);
      sts.count_bad  = ({1'b0, b} > 9'(MAX_SAMPLES));
      sts.total_zero = (total_ff == 8'd0);
      sts.data_last  = (lane_ff == LANE_B2) &&
                       ((9'(wr_idx_ff) + 9'd1) == {1'b0, total_ff});
      sts.sum_match  = (sum_ff == expect_ff);
      sts.eoc        = (end_ff < start_ff);
      sts.read_last  = ((9'(rd_idx_ff) + 9'd1) == {1'b0, total_ff});
      sts.slot_free  = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      type_in   = type_ff;
      total_in  = total_ff;
      start_in  = start_ff;
      end_in    = end_ff;
      expect_in = expect_ff;
      sum_in    = sum_ff;
      lane_in   = lane_ff;
      wr_idx_in = wr_idx_ff;
      unique case (cmd.byte_op)
         BOP_NONE: begin
         end
         BOP_TYPE: begin
            type_in = b;
            sum_in  = SUM_SEED ^ {8'h00, b};
         end
         BOP_COUNT: begin
            if (!sts.count_bad) begin
               total_in = b;
               sum_in   = sum_ff ^ {b, 8'h00};
            end
         end
         BOP_FSA_LO: begin
            start_in = {8'h00, b};
            sum_in   = sum_ff ^ {8'h00, b};
         end
         BOP_FSA_HI: begin
            start_in = {b, start_ff[7:0]};
            sum_in   = sum_ff ^ {b, 8'h00};
         end
         BOP_LSA_LO: begin
            end_in = {8'h00, b};
            sum_in = sum_ff ^ {8'h00, b};
         end
         BOP_LSA_HI: begin
            end_in = {b, end_ff[7:0]};
            sum_in = sum_ff ^ {b, 8'h00};
         end
         BOP_CS_LO: begin
            expect_in = {8'h00, b};
         end
         BOP_CS_HI: begin
            expect_in = {b, expect_ff[7:0]};
         end
         BOP_DATA: begin
            // third byte of a triple goes into the high half of the sum
            if (lane_ff == LANE_B2) begin
               sum_in    = sum_ff ^ {b, 8'h00};
               lane_in   = LANE_B0;
               wr_idx_in = wr_idx_ff + IW'(1);
            end else begin
               sum_in  = sum_ff ^ {8'h00, b};
               lane_in = lane_ff + 2'd1;
            end
         end
         default: begin
         end
      endcase
      if (cmd.wr_clr) begin
         lane_in   = LANE_B0;
         wr_idx_in = '0;
      end
   end

   always_comb begin
      errors_in = errors_ff;
      if (cmd.err_clr) begin
         errors_in = '0;
      end else if (cmd.err_inc) begin
         errors_in = errors_ff + 32'd1;
      end
      cycles_in = cycles_ff;
      if (cmd.cyc_inc) begin
         cycles_in = cycles_ff + 32'd1;
      end
      rd_idx_in = rd_idx_ff;
      if (cmd.rd_clr) begin
         rd_idx_in = '0;
      end else if (cmd.load_sample) begin
         rd_idx_in = rd_idx_ff + IW'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_sample || cmd.load_error) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      rsp_in              = rsp_ff;
      rsp_in.angle_start  = start_ff;
      rsp_in.angle_end    = end_ff;
      rsp_in.packet_type  = type_ff;
      rsp_in.error_count  = errors_in;
      rsp_in.cycle_count  = cycles_in;
      if (cmd.load_error) begin
         rsp_in.status       = 1'b1;
         rsp_in.sample_index = '0;
         rsp_in.intensity    = '0;
         rsp_in.distance     = '0;
         rsp_in.distance_ok  = 1'b0;
         rsp_in.end_of_cycle = 1'b0;
         rsp_in.last         = 1'b1;
      end else begin
         rsp_in.status       = 1'b0;
         rsp_in.sample_index = rd_idx8[5:0];
         rsp_in.intensity    = rd_b0_ff;
         rsp_in.distance     = {rd_b2_ff, rd_b1_ff[7:2]};
         rsp_in.distance_ok  = (rd_b1_ff[1:0] == 2'b00);
         rsp_in.end_of_cycle = sts.eoc;
         rsp_in.last         = sts.read_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         type_ff      <= '0;
         total_ff     <= '0;
         start_ff     <= '0;
         end_ff       <= '0;
         expect_ff    <= '0;
         sum_ff       <= '0;
         lane_ff      <= LANE_B0;
         wr_idx_ff    <= '0;
         rd_idx_ff    <= '0;
         errors_ff    <= '0;
         cycles_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         type_ff      <= type_in;
         total_ff     <= total_in;
         start_ff     <= start_in;
         end_ff       <= end_in;
         expect_ff    <= expect_in;
         sum_ff       <= sum_in;
         lane_ff      <= lane_in;
         wr_idx_ff    <= wr_idx_in;
         rd_idx_ff    <= rd_idx_in;
         errors_ff    <= errors_in;
         cycles_ff    <= cycles_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_sample || cmd.load_error) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.byte_op == BOP_DATA) begin
         unique case (lane_ff)
            LANE_B0: mem0[wr_idx_ff] <= b;
            LANE_B1: mem1[wr_idx_ff] <= b;
            LANE_B2: mem2[wr_idx_ff] <= b;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_issue) begin
         rd_b0_ff <= mem0[rd_idx_ff];
         rd_b1_ff <= mem1[rd_idx_ff];
         rd_b2_ff <= mem2[rd_idx_ff];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: rtl/lpd_ctrl.sv
// Controller: packet parse and sample readout state machine.
`timescale 1ns / 1ps

module lpd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 restart,
   input  lpd_pkg::status_type  sts,
   output lpd_pkg::cmd_type     cmd
);
   import lpd_pkg::*;

   state_type state_ff, state_in;
   logic      accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT_LO;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.byte_op = BOP_NONE;
      req_ready = (state_ff != ST_CHECK) && (state_ff != ST_RD_ISSUE) &&
                  (state_ff != ST_RD_LOAD);
      accept = req_valid && req_ready;

      if (accept && restart) begin
         cmd.err_clr = 1'b1;
         cmd.wr_clr  = 1'b1;
         state_in    = ST_HUNT_LO;
      end else begin
         unique case (state_ff)
            ST_HUNT_LO: begin
               if (accept) begin
                  if (sts.hdr_lo_ok) begin
                     state_in = ST_HUNT_HI;
                  end else begin
                     cmd.err_inc = 1'b1;
                  end
               end
            end
            ST_HUNT_HI: begin
               if (accept) begin
                  if (sts.hdr_hi_ok) begin
                     state_in = ST_TYPE;
                  end else begin
                     cmd.err_inc = 1'b1;
                     state_in    = ST_HUNT_LO;
                  end
               end
            end
            ST_TYPE: begin
               if (accept) begin
                  cmd.byte_op = BOP_TYPE;
                  state_in    = ST_COUNT;
               end
            end
            ST_COUNT: begin
               if (accept) begin
                  cmd.byte_op = BOP_COUNT;
                  if (sts.count_bad) begin
                     cmd.err_inc = 1'b1;
                     state_in    = ST_HUNT_LO;
                  end else begin
                     state_in = ST_FSA_LO;
                  end
               end
            end
            ST_FSA_LO: begin
               if (accept) begin
                  cmd.byte_op = BOP_FSA_LO;
                  state_in    = ST_FSA_HI;
               end
            end
            ST_FSA_HI: begin
               if (accept) begin
                  cmd.byte_op = BOP_FSA_HI;
                  state_in    = ST_LSA_LO;
               end
            end
            ST_LSA_LO: begin
               if (accept) begin
                  cmd.byte_op = BOP_LSA_LO;
                  state_in    = ST_LSA_HI;
               end
            end
            ST_LSA_HI: begin
               if (accept) begin
                  cmd.byte_op = BOP_LSA_HI;
                  state_in    = ST_CS_LO;
               end
            end
            ST_CS_LO: begin
               if (accept) begin
                  cmd.byte_op = BOP_CS_LO;
                  state_in    = ST_CS_HI;
               end
            end
            ST_CS_HI: begin
               if (accept) begin
                  cmd.byte_op = BOP_CS_HI;
                  cmd.wr_clr  = 1'b1;
                  state_in    = sts.total_zero ? ST_CHECK : ST_DATA;
               end
            end
            ST_DATA: begin
               if (accept) begin
                  cmd.byte_op = BOP_DATA;
                  if (sts.data_last) begin
                     state_in = ST_CHECK;
                  end
               end
            end
            ST_CHECK: begin
               // bad sum: wait for the result slot, then one error result
               if (!sts.sum_match) begin
                  if (sts.slot_free) begin
                     cmd.err_inc    = 1'b1;
                     cmd.load_error = 1'b1;
                     state_in       = ST_HUNT_LO;
                  end
               end else begin
                  cmd.cyc_inc = sts.eoc;
                  cmd.rd_clr  = 1'b1;
                  state_in    = sts.total_zero ? ST_HUNT_LO : ST_RD_ISSUE;
               end
            end
            ST_RD_ISSUE: begin
               cmd.rd_issue = 1'b1;
               state_in     = ST_RD_LOAD;
            end
            ST_RD_LOAD: begin
               if (sts.slot_free) begin
                  cmd.load_sample = 1'b1;
                  state_in        = sts.read_last ? ST_HUNT_LO : ST_RD_ISSUE;
               end
            end
            default: begin
               state_in = ST_HUNT_LO;
            end
         endcase
      end
   end

endmodule

FILE: rtl/lidar_packet_deframer_top.sv
// Top level: lidar packet deframer, controller plus datapath.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | req_data (req_item_type)
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_data (rsp_item_type)
//
// Header, field and sample bytes are taken one per cycle, one request each.
// After the last byte of a packet req_ready drops for the checksum compare and
// then, per sample, a registered sample memory read and the result register
// load, so a packet holds the input until its last result is loaded.
// A stalled result holds the readout; reset is synchronous and clears control
// state and counters, the sample memory is not cleared.
`timescale 1ns / 1ps

module lidar_packet_deframer_top #(
   parameter int MAX_SAMPLES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  lpd_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output lpd_pkg::rsp_item_type rsp_data
);
   import lpd_pkg::*;

   cmd_type    cmd;
   status_type sts;

   lpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .restart   (req_data.req_type),
      .sts       (sts),
      .cmd       (cmd)
   );

   lpd_datapath #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // results are only produced while the input side is held off
   a_no_load_while_ready: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && (cmd.load_sample || cmd.load_error)))
      else $error("result loaded while accepting requests");

   // never overwrite a result that has not been taken
   a_load_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_sample || cmd.load_error) |-> sts.slot_free)
      else $error("result register overwritten");

   // error result only on a checksum mismatch
   a_error_on_mismatch: assert property (@(posedge clock) disable iff (reset)
      cmd.load_error |-> (!sts.sum_match && cmd.err_inc))
      else $error("error result without checksum mismatch");

   // a loaded result shows up as valid in the next cycle
   a_load_gives_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_sample || cmd.load_error) |=> rsp_valid)
      else $error("loaded result not presented");
`endif

endmodule

FILE: dv/tb.sv
// Testbench: lidar packet deframer, random byte streams checked against a predictor.
`timescale 1ns / 1ps

module tb;
   import lpd_pkg::*;

   localparam int MAX_SAMPLES = 64;
   localparam int TAIL_CYCLES = 2 * MAX_SAMPLES + 40;

   typedef struct {
      req_item_type item;
      bit           drain;   // hold this request until all results are back
   } rx_entry_type;

   typedef enum int {RCV_OPEN, RCV_RANDOM, RCV_SPARSE} rcv_mode_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_item_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_item_type rsp_data;

   rx_entry_type rx_stream_q [$];
   rsp_item_type scan_results_q [$];
   int           fail_count = 0;
   bit           req_taken = 1'b0;
   bit           rsp_hold = 1'b0;

   // predictor state
   state_type   pr_phase = ST_HUNT_LO;
   logic [7:0]  pr_type = '0;
   logic [7:0]  pr_total = '0;
   logic [15:0] pr_start = '0;
   logic [15:0] pr_end = '0;
   logic [15:0] pr_want_sum = '0;
   logic [15:0] pr_sum = '0;
   int          pr_index = 0;
   logic [7:0]  pr_store [0:3*MAX_SAMPLES-1];
   logic [31:0] pr_errors = '0;
   logic [31:0] pr_cycles = '0;

   lidar_packet_deframer_top #(
      .MAX_SAMPLES(MAX_SAMPLES)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always #6 clock = ~clock;

   function automatic rsp_item_type scan_result(logic st, logic [5:0] idx, logic [7:0] inten,
                                                logic [13:0] dval, logic ok, logic eoc,
                                                logic lst);
      rsp_item_type r;
      r.status       = st;
      r.sample_index = idx;
      r.intensity    = inten;
      r.distance     = dval;
      r.distance_ok  = ok;
      r.angle_start  = pr_start;
      r.angle_end    = pr_end;
      r.packet_type  = pr_type;
      r.end_of_cycle = eoc;
      r.last         = lst;
      r.error_count  = pr_errors;
      r.cycle_count  = pr_cycles;
      return r;
   endfunction

   function automatic void close_packet();
      logic       eoc;
      logic [7:0] b0, b1, b2;
      pr_phase = ST_HUNT_LO;
      if (pr_sum != pr_want_sum) begin
         pr_errors++;
         scan_results_q.push_back(scan_result(1'b1, '0, '0, '0, 1'b0, 1'b0, 1'b1));
      end else begin
         eoc = pr_end < pr_start;
         if (eoc) pr_cycles++;
         for (int i = 0; i < int'(pr_total) && i < MAX_SAMPLES; i++) begin
            b0 = pr_store[3*i];
            b1 = pr_store[3*i+1];
            b2 = pr_store[3*i+2];
            scan_results_q.push_back(scan_result(1'b0, i[5:0], b0, {b2, b1[7:2]},
                                                 b1[1:0] == 2'b00, eoc,
                                                 i + 1 == int'(pr_total)));
         end
      end
   endfunction

   // advance the predictor by one accepted request
   function automatic void deframe_byte(req_item_type r);
      logic [7:0] b;
      b = r.rx_byte;
      if (r.req_type) begin
         pr_phase  = ST_HUNT_LO;
         pr_index  = 0;
         pr_errors = '0;
         return;
      end
      case (pr_phase)
         ST_HUNT_LO: begin
            if (b == HDR_LO) pr_phase = ST_HUNT_HI;
            else pr_errors++;
         end
         ST_HUNT_HI: begin
            if (b == HDR_HI) begin
               pr_phase = ST_TYPE;
            end else begin
               pr_phase = ST_HUNT_LO;
               pr_errors++;
            end
         end
         ST_TYPE: begin
            pr_type  = b;
            pr_sum   = SUM_SEED ^ {8'h00, b};
            pr_phase = ST_COUNT;
         end
         ST_COUNT: begin
            if (int'(b) > MAX_SAMPLES) begin
               pr_errors++;
               pr_phase = ST_HUNT_LO;
            end else begin
               pr_total = b;
               pr_sum  ^= {b, 8'h00};
               pr_phase = ST_FSA_LO;
            end
         end
         ST_FSA_LO: begin
            pr_start = {8'h00, b};
            pr_sum  ^= {8'h00, b};
            pr_phase = ST_FSA_HI;
         end
         ST_FSA_HI: begin
            pr_start[15:8] = b;
            pr_sum  ^= {b, 8'h00};
            pr_phase = ST_LSA_LO;
         end
         ST_LSA_LO: begin
            pr_end   = {8'h00, b};
            pr_sum  ^= {8'h00, b};
            pr_phase = ST_LSA_HI;
         end
         ST_LSA_HI: begin
            pr_end[15:8] = b;
            pr_sum  ^= {b, 8'h00};
            pr_phase = ST_CS_LO;
         end
         ST_CS_LO: begin
            pr_want_sum = {8'h00, b};
            pr_phase    = ST_CS_HI;
         end
         ST_CS_HI: begin
            pr_want_sum[15:8] = b;
            pr_index = 0;
            if (pr_total == 8'd0) close_packet();
            else pr_phase = ST_DATA;
         end
         ST_DATA: begin
            if (pr_index < 3 * MAX_SAMPLES) begin
               pr_store[pr_index] = b;
               // third byte of a triple lands in the high half of the sum
               if (pr_index % 3 == 2) pr_sum ^= {b, 8'h00};
               else pr_sum ^= {8'h00, b};
            end
            pr_index++;
            if (pr_index >= 3 * int'(pr_total)) close_packet();
         end
         default: pr_phase = ST_HUNT_LO;
      endcase
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   // request acceptance and result checking
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) deframe_byte(req_data);
         if (rsp_valid && rsp_ready) begin
            if (scan_results_q.size() == 0) begin
               $error("unexpected result: %p", rsp_data);
               fail_count++;
            end else begin
               want = scan_results_q.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_data.status));
               check_field("sample_index", 32'(want.sample_index),
                           32'(rsp_data.sample_index));
               check_field("intensity", 32'(want.intensity), 32'(rsp_data.intensity));
               check_field("distance", 32'(want.distance), 32'(rsp_data.distance));
               check_field("distance_ok", 32'(want.distance_ok), 32'(rsp_data.distance_ok));
               check_field("angle_start", 32'(want.angle_start), 32'(rsp_data.angle_start));
               check_field("angle_end", 32'(want.angle_end), 32'(rsp_data.angle_end));
               check_field("packet_type", 32'(want.packet_type), 32'(rsp_data.packet_type));
               check_field("end_of_cycle", 32'(want.end_of_cycle),
                           32'(rsp_data.end_of_cycle));
               check_field("last", 32'(want.last), 32'(rsp_data.last));
               check_field("error_count", want.error_count, rsp_data.error_count);
               check_field("cycle_count", want.cycle_count, rsp_data.cycle_count);
            end
         end
      end
   end

   // request driver: bursts with random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (rx_stream_q.size() != 0 &&
                      !(rx_stream_q[0].drain && scan_results_q.size() != 0)) begin
            req_valid <= 1'b1;
            req_data  <= rx_stream_q[0].item;
            void'(rx_stream_q.pop_front());
            if (burst_left <= 1) begin
               burst_left = int'($urandom_range(1, 24));
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result stall pattern
   rcv_mode_type rcv_mode = RCV_OPEN;
   int rcv_tick = 0;
   always @(negedge clock) begin
      logic rdy;
      rcv_tick++;
      if (rcv_tick % 97 == 0) rcv_mode = rcv_mode_type'($urandom_range(0, 2));
      case (rcv_mode)
         RCV_OPEN:   rdy = 1'b1;
         RCV_RANDOM: rdy = 1'($urandom_range(0, 1));
         default:    rdy = (rcv_tick % 5 == 0);
      endcase
      rsp_ready <= rdy && !rsp_hold && !reset;
   end

   // long receiver hold-off so the block backs up into its input
   initial begin
      while (reset) @(posedge clock);
      repeat (20) @(posedge clock);
      while (scan_results_q.size() == 0) @(posedge clock);
      rsp_hold = 1'b1;
      repeat (300) @(posedge clock);
      rsp_hold = 1'b0;
   end

   function automatic void push_request(logic rt, logic [7:0] b, bit drain);
      rx_entry_type e;
      e.item.req_type = rt;
      e.item.rx_byte  = b;
      e.drain         = drain;
      rx_stream_q.push_back(e);
   endfunction

   // fill < 0 gives random sample bytes, otherwise every sample byte is fill
   function automatic void push_packet(logic [7:0] ptype, int count, logic [15:0] sa,
                                       logic [15:0] ea, bit bad_sum, int fill, bit drain);
      logic [7:0]  hdr [8];
      logic [7:0]  smp [$];
      logic [7:0]  b0, b1, b2;
      logic [15:0] sum;
      sum = SUM_SEED ^ {8'h00, ptype} ^ {count[7:0], 8'h00} ^ sa ^ ea;
      hdr = '{HDR_LO, HDR_HI, ptype, count[7:0], sa[7:0], sa[15:8], ea[7:0], ea[15:8]};
      for (int i = 0; i < count; i++) begin
         if (fill >= 0) begin
            b0 = fill[7:0];
            b1 = fill[7:0];
            b2 = fill[7:0];
         end else begin
            b0 = 8'($urandom);
            b1 = 8'($urandom);
            b2 = 8'($urandom);
            if ($urandom_range(0, 1) == 1) b1[1:0] = 2'b00;
         end
         smp.push_back(b0);
         smp.push_back(b1);
         smp.push_back(b2);
         sum ^= {8'h00, b0} ^ {b2, b1};
      end
      if (bad_sum) sum ^= 16'h0001 << $urandom_range(0, 15);
      push_request(1'b0, hdr[0], drain);
      for (int i = 1; i < 8; i++) push_request(1'b0, hdr[i], 1'b0);
      push_request(1'b0, sum[7:0], 1'b0);
      push_request(1'b0, sum[15:8], 1'b0);
      foreach (smp[i]) push_request(1'b0, smp[i], 1'b0);
   endfunction

   initial begin
      // stray bytes, then a broken header
      push_request(1'b0, 8'h00, 1'b0);
      push_request(1'b0, HDR_LO, 1'b0);
      push_request(1'b0, 8'h00, 1'b0);
      push_packet(8'h01, 4, 16'h1000, 16'h2000, 1'b0, -1, 1'b0);
      push_packet(8'h02, 2, 16'h2000, 16'h3000, 1'b1, -1, 1'b0);
      push_request(1'b1, 8'h00, 1'b1);
      // empty packets: one wrapping rotation, one with a bad sum
      push_packet(8'h03, 0, 16'h9000, 16'h0100, 1'b0, -1, 1'b0);
      push_packet(8'h04, 0, 16'h0100, 16'h0200, 1'b1, -1, 1'b0);
      // count above the limit, then restart
      push_request(1'b0, HDR_LO, 1'b0);
      push_request(1'b0, HDR_HI, 1'b0);
      push_request(1'b0, 8'h07, 1'b0);
      push_request(1'b0, 8'(MAX_SAMPLES + 1), 1'b0);
      push_request(1'b1, 8'h5A, 1'b0);
      push_packet(8'h05, 20, 16'hF000, 16'h0010, 1'b0, -1, 1'b1);
      push_packet(8'h06, 5, 16'h0010, 16'h0400, 1'b0, 8'hFF, 1'b0);

      repeat (3) @(negedge clock);
      reset = 1'b0;

      while (rx_stream_q.size() != 0 || req_valid) @(posedge clock);
      while (scan_results_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && scan_results_q.size() == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   initial begin
      #200000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
